// ===== rtl/rgbhsv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared widths and the stage-to-stage pixel record of the colour converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int CHAN_W           = 8;
    localparam int HUE_W            = 15;
    localparam int HUE_FRAC_DEFAULT = 6;
    localparam int SECTOR_W         = 2;
    localparam int QUO_W            = 9;
    localparam int DIV_STEPS        = 9;

    localparam logic [SECTOR_W-1:0] SECTOR_RED   = 2'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_GREEN = 2'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_BLUE  = 2'd2;

    // Pixel record handed from the min/max stage to the divider pipeline
    typedef struct packed {
        logic [CHAN_W-1:0]   hi;
        logic [CHAN_W-1:0]   d;
        logic [SECTOR_W-1:0] sector;
        logic                neg;
        logic [CHAN_W-1:0]   diff;
    } pix_t;

endpackage : rgbhsv_pkg
`default_nettype wire

// ===== rtl/rgbhsv_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_front
// Registered min/max stage: value, channel span, sector and hue difference.
// ----------------------------------------------------------------------------
module rgbhsv_front
    import rgbhsv_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [CHAN_W-1:0] red,
    input  wire logic [CHAN_W-1:0] green,
    input  wire logic [CHAN_W-1:0] blue,
    output logic                   out_valid,
    output pix_t                   out_pix
);

    logic [CHAN_W-1:0] hi, lo;
    pix_t              pix_next;
    logic              valid_reg;
    pix_t              pix_reg;

    always_comb begin
        hi = (red > green) ? red : green;
        if (blue > hi) hi = blue;
        lo = (red < green) ? red : green;
        if (blue < lo) lo = blue;
        pix_next.hi = hi;
        pix_next.d  = hi - lo;
        // Red wins ties, then green
        if (hi == red) begin
            pix_next.sector = SECTOR_RED;
            pix_next.neg    = green < blue;
            pix_next.diff   = (green < blue) ? blue - green : green - blue;
        end else if (hi == green) begin
            pix_next.sector = SECTOR_GREEN;
            pix_next.neg    = blue < red;
            pix_next.diff   = (blue < red) ? red - blue : blue - red;
        end else begin
            pix_next.sector = SECTOR_BLUE;
            pix_next.neg    = red < green;
            pix_next.diff   = (red < green) ? green - red : red - green;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) pix_reg <= pix_next;
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule : rgbhsv_front
`default_nettype wire

// ===== rtl/rgbhsv_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_div
// Pipelined restoring divider, one quotient bit per stage, two lanes:
// diff*60*2^F / d for hue and d*255 / hi for saturation. Stage 0 registers
// the products and each following stage resolves one quotient bit.
// ----------------------------------------------------------------------------
module rgbhsv_div
    import rgbhsv_pkg::*;
#(
    parameter int HUE_FRAC = HUE_FRAC_DEFAULT
)(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  pix_t                  in_pix,
    output logic                  out_valid,
    output logic [HUE_W-1:0]      hue,
    output logic [CHAN_W-1:0]     saturation,
    output logic [CHAN_W-1:0]     brightness
);

    // Hue quotient at most 60*2^F, quotient bits = width of that bound
    localparam int SIXTY = 60 << HUE_FRAC;
    localparam int HQ_W  = $clog2(SIXTY + 1);
    localparam int HN_W  = HQ_W + CHAN_W;
    localparam int SN_W  = 2 * CHAN_W;
    localparam int HSTG  = HQ_W;
    localparam int NSTG  = (HSTG > DIV_STEPS) ? HSTG : DIV_STEPS;
    localparam int HOUT_W = HQ_W + 3;

    logic [HN_W-1:0]   hn   [0:NSTG];
    logic [HQ_W-1:0]   hq   [0:NSTG];
    logic [SN_W-1:0]   sn   [0:NSTG];
    logic [QUO_W-1:0]  sq   [0:NSTG];
    pix_t              pp   [0:NSTG];
    logic              vv   [0:NSTG];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NSTG; i++) vv[i] <= 1'b0;
        end else if (en) begin
            vv[0] <= in_valid;
            for (int i = 1; i <= NSTG; i++) vv[i] <= vv[i-1];
        end
        if (en) begin
            hn[0] <= HN_W'(in_pix.diff * SIXTY);
            sn[0] <= SN_W'(in_pix.d) * SN_W'(255);
            hq[0] <= '0;
            sq[0] <= '0;
            pp[0] <= in_pix;
            for (int i = 1; i <= NSTG; i++) begin
                pp[i] <= pp[i-1];
                if (i <= HSTG && pp[i-1].d != '0 &&
                    (hn[i-1] >> (HSTG - i)) >= HN_W'(pp[i-1].d)) begin
                    hn[i] <= hn[i-1] - (HN_W'(pp[i-1].d) << (HSTG - i));
                    hq[i] <= hq[i-1] | (HQ_W'(1) << (HSTG - i));
                end else begin
                    hn[i] <= hn[i-1];
                    hq[i] <= hq[i-1];
                end
                if (i <= DIV_STEPS && pp[i-1].hi != '0 &&
                    (sn[i-1] >> (DIV_STEPS - i)) >= SN_W'(pp[i-1].hi)) begin
                    sn[i] <= sn[i-1] - (SN_W'(pp[i-1].hi) << (DIV_STEPS - i));
                    sq[i] <= sq[i-1] | (QUO_W'(1) << (DIV_STEPS - i));
                end else begin
                    sn[i] <= sn[i-1];
                    sq[i] <= sq[i-1];
                end
            end
        end
    end

    // Sector offset and wrap of negative red-sector hue; a negative term in
    // the green or blue sector rounds the whole quotient down, so take one
    // more off when the division left a remainder
    logic [HOUT_W-1:0] h_full;
    logic [HOUT_W-1:0] h_round;
    pix_t              pl;
    assign pl      = pp[NSTG];
    assign h_round = HOUT_W'(hq[NSTG]) + HOUT_W'(hn[NSTG] != '0);
    always_comb begin
        unique case (pl.sector)
            SECTOR_GREEN: h_full = pl.neg ? HOUT_W'(2*SIXTY) - h_round
                                          : HOUT_W'(2*SIXTY) + HOUT_W'(hq[NSTG]);
            SECTOR_BLUE:  h_full = pl.neg ? HOUT_W'(4*SIXTY) - h_round
                                          : HOUT_W'(4*SIXTY) + HOUT_W'(hq[NSTG]);
            default:      h_full = (pl.neg && hq[NSTG] != '0)
                                   ? HOUT_W'(6*SIXTY) - HOUT_W'(hq[NSTG])
                                   : HOUT_W'(hq[NSTG]);
        endcase
        if (pl.d == '0) h_full = '0;
    end

    logic [HUE_W-1:0] hue_ext;
    generate
        if (HOUT_W >= HUE_W) begin : g_trunc
            assign hue_ext = h_full[HUE_W-1:0];
        end else begin : g_ext
            assign hue_ext = HUE_W'(h_full);
        end
    endgenerate

    assign out_valid  = vv[NSTG];
    assign hue        = hue_ext;
    assign saturation = sq[NSTG][CHAN_W-1:0];
    assign brightness = pl.hi;

endmodule : rgbhsv_div
`default_nettype wire

// ===== rtl/rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Streaming RGB to HSV conversion, one pixel per clock while not stalled.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns hue
// (1/2^HUE_FRAC degree units), saturation and brightness through the front
// register, the one-bit-per-stage divider pipeline and the output register;
// a stall freezes the whole pipeline while the output register holds its
// beat, and ready falls only when that register is full and not being
// taken.
module rgb_to_hsv_converter
    import rgbhsv_pkg::*;
#(
    parameter int HUE_FRAC = HUE_FRAC_DEFAULT
)(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CHAN_W-1:0] s_red,
    input  wire logic [CHAN_W-1:0] s_green,
    input  wire logic [CHAN_W-1:0] s_blue,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [HUE_W-1:0]       m_hue,
    output logic [CHAN_W-1:0]      m_saturation,
    output logic [CHAN_W-1:0]      m_brightness
);

    logic             en;
    logic             f_valid, d_valid;
    pix_t             f_pix;
    logic [HUE_W-1:0] d_hue;
    logic [CHAN_W-1:0] d_sat, d_bri;
    logic             valid_reg;
    logic [HUE_W-1:0] hue_reg;
    logic [CHAN_W-1:0] sat_reg, bri_reg;

    // Advance whenever the output register is free or being drained
    assign en      = !valid_reg || m_ready;
    assign s_ready = en;

    rgbhsv_front u_front (
        .aclk, .aresetn, .en,
        .in_valid (s_valid),
        .red      (s_red),
        .green    (s_green),
        .blue     (s_blue),
        .out_valid(f_valid),
        .out_pix  (f_pix)
    );

    rgbhsv_div #(.HUE_FRAC(HUE_FRAC)) u_div (
        .aclk, .aresetn, .en,
        .in_valid  (f_valid),
        .in_pix    (f_pix),
        .out_valid (d_valid),
        .hue       (d_hue),
        .saturation(d_sat),
        .brightness(d_bri)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= d_valid;
        end
        if (en) begin
            hue_reg <= d_hue;
            sat_reg <= d_sat;
            bri_reg <= d_bri;
        end
    end

    assign m_valid      = valid_reg;
    assign m_hue        = hue_reg;
    assign m_saturation = sat_reg;
    assign m_brightness = bri_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hue) && $stable(m_saturation))
        else $error("output beat changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_brightness == '0 |-> m_saturation == '0 && m_hue == '0)
        else $error("black pixel with nonzero hue or saturation");

endmodule : rgb_to_hsv_converter
`default_nettype wire

// ===== dv/tb_rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter
// Self-checking bench for the streaming RGB to HSV converter: directed corner
// pixels then random pixels, with random gaps on the pixel input and random
// stalls on the result output, each result checked against an integer model.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter;
    import rgbhsv_pkg::*;

    localparam int HUE_FRAC = HUE_FRAC_DEFAULT;
    localparam int N_RANDOM = 900;
    localparam int RGB_W    = 3 * CHAN_W;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
    } hsv_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [CHAN_W-1:0] s_red;
    logic [CHAN_W-1:0] s_green;
    logic [CHAN_W-1:0] s_blue;
    logic              m_valid;
    logic              m_ready;
    logic [HUE_W-1:0]  m_hue;
    logic [CHAN_W-1:0] m_saturation;
    logic [CHAN_W-1:0] m_brightness;

    rgb_t pending_pixels[$];
    hsv_t expected_hsv[$];
    int   n_errors;
    int   n_checked;
    bit   stim_done;
    int   gap_left;
    int   stall_left;

    rgb_to_hsv_converter #(.HUE_FRAC(HUE_FRAC)) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue        (m_hue),
        .m_saturation (m_saturation),
        .m_brightness (m_brightness)
    );

    function automatic hsv_t convert_pixel(rgb_t px);
        longint r, g, b, hi, lo, d, sixty, h, s;
        hsv_t res;
        r = longint'(px.red);
        g = longint'(px.green);
        b = longint'(px.blue);
        hi = r > g ? r : g;
        hi = hi > b ? hi : b;
        lo = r < g ? r : g;
        lo = lo < b ? lo : b;
        d = hi - lo;
        sixty = 60 * (longint'(1) << HUE_FRAC);
        h = 0;
        s = 0;
        if (hi > 0) s = (d * 255) / hi;
        if (d > 0) begin
            if (hi == r) h = (sixty * (g - b)) / d;
            else if (hi == g) h = (sixty * (b - r + 2 * d)) / d;
            else h = (sixty * (r - g + 4 * d)) / d;
            if (h < 0) h += 6 * sixty;
        end
        res.hue = h[HUE_W-1:0];
        res.sat = s[CHAN_W-1:0];
        res.val = hi[CHAN_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, want %0d", what, got, want);
        n_errors++;
    endtask

    function automatic int draw_wait();
        // leave long runs with no idling at all
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic rgb_t mk(int r, int g, int b);
        rgb_t p;
        p.red = CHAN_W'(r);
        p.green = CHAN_W'(g);
        p.blue = CHAN_W'(b);
        return p;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        rgb_t p;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        // black, white, grey, primaries, secondaries, ties and wrap cases
        pending_pixels.push_back(mk(0, 0, 0));
        pending_pixels.push_back(mk(255, 255, 255));
        pending_pixels.push_back(mk(128, 128, 128));
        pending_pixels.push_back(mk(1, 1, 1));
        pending_pixels.push_back(mk(255, 0, 0));
        pending_pixels.push_back(mk(0, 255, 0));
        pending_pixels.push_back(mk(0, 0, 255));
        pending_pixels.push_back(mk(255, 255, 0));
        pending_pixels.push_back(mk(0, 255, 255));
        pending_pixels.push_back(mk(255, 0, 255));
        pending_pixels.push_back(mk(255, 0, 1));
        pending_pixels.push_back(mk(255, 254, 255));
        pending_pixels.push_back(mk(1, 0, 0));
        pending_pixels.push_back(mk(0, 1, 0));
        pending_pixels.push_back(mk(0, 0, 1));
        pending_pixels.push_back(mk(200, 200, 10));
        pending_pixels.push_back(mk(10, 200, 200));
        pending_pixels.push_back(mk(255, 1, 254));
        pending_pixels.push_back(mk(170, 85, 255));
        pending_pixels.push_back(mk(254, 255, 0));
        pending_pixels.push_back(mk(100, 255, 30));
        pending_pixels.push_back(mk(7, 20, 255));
        for (int i = 0; i < N_RANDOM; i++) begin
            case ($urandom_range(0, 4))
                0: p = mk($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
                1: begin
                    // near-grey pixels stress the small divisors
                    p.red = CHAN_W'($urandom_range(0, 255));
                    p.green = p.red ^ CHAN_W'($urandom_range(0, 3));
                    p.blue = p.red ^ CHAN_W'($urandom_range(0, 3));
                end
                2: begin
                    // forced ties between two channels
                    p.red = CHAN_W'($urandom_range(0, 255));
                    p.green = $urandom_range(0, 1) ? p.red
                                                   : CHAN_W'($urandom_range(0, 255));
                    p.blue = $urandom_range(0, 1) ? p.green
                                                  : CHAN_W'($urandom_range(0, 255));
                end
                3: p = mk($urandom_range(0, 1) * 255, $urandom_range(0, 255),
                          $urandom_range(0, 1) * 255);
                default: p = rgb_t'(RGB_W'($urandom));
            endcase
            pending_pixels.push_back(p);
        end
        wait (pending_pixels.size() == 0 && !s_valid);
        wait (expected_hsv.size() == 0);
        repeat (40) @(posedge aclk);
        $display("converted %0d pixels with random input gaps and output stalls",
                 n_checked);
        if (n_errors == 0 && expected_hsv.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Driver: hold the beat until taken, then wait a drawn gap before the next.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_red    <= '0;
            s_green  <= '0;
            s_blue   <= '0;
            gap_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) expected_hsv.push_back(convert_pixel({s_red, s_green, s_blue}));
            if (gap_left > 0 && s_valid) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_pixels.size() > 0) begin
                rgb_t p;
                p = pending_pixels.pop_front();
                s_valid  <= 1'b1;
                s_red    <= p.red;
                s_green  <= p.green;
                s_blue   <= p.blue;
                gap_left <= draw_wait();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result beat and draw the next stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_hsv.size() == 0) begin
                    $display("result beat with no pixel outstanding");
                    n_errors++;
                end else begin
                    hsv_t e;
                    e = expected_hsv.pop_front();
                    n_checked++;
                    if (m_hue !== e.hue)
                        report_mismatch("hue", int'(m_hue), int'(e.hue));
                    if (m_saturation !== e.sat)
                        report_mismatch("saturation", int'(m_saturation), int'(e.sat));
                    if (m_brightness !== e.val)
                        report_mismatch("brightness", int'(m_brightness), int'(e.val));
                end
            end
            if (stall_left > 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (m_valid && m_ready) begin
                stall_left <= draw_wait();
                m_ready    <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
